// ===== hdl/btc_pkg.sv =====
// Package for the block transposition cipher.
// Holds register codes, fixed field widths and the sequencer state type.
// No dependencies.
package btc_pkg;

    localparam int BYTE_W    = 8;
    localparam int EXT_W     = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [EXT_W-1:0] WIDTH_RESET  = 4'd8;
    localparam logic [EXT_W-1:0] HEIGHT_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RECALC = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_PLACE  = 4'b1000
    } state_t;

endpackage

// ===== hdl/block_transposition_cipher.sv =====
// Top level of the block transposition cipher.
// Depends on btc_pkg and btc_ram (cell store).
//
// Bytes are written into a cell RAM at one byte per cycle while a block fills.
// When the rectangle is full or a byte flagged message_end is stored, the block
// stalls its input and scans the rectangle one cell per cycle, reading every
// filled cell out of the RAM read port; a stall on the result side holds the
// scan. If the extents were shrunk to or below the fill count, the old block is
// flushed before the new byte is stored. After any configuration write the input
// stalls while the fill coordinates are recomputed by stepping from zero. The
// output register lets a new byte be taken while the last result still waits.
module block_transposition_cipher #(
    parameter int MAX_WIDTH  = 8,
    parameter int MAX_HEIGHT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [btc_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          message_end,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [btc_pkg::BYTE_W-1:0]    out_byte,
    output logic                          run_last,
    output logic                          message_done,
    input  logic                          cfg_we,
    input  logic [btc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [btc_pkg::EXT_W-1:0]     cfg_data
);

    localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CW     = $clog2(NCELLS + 1);
    localparam int FW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW     = (FW > SW) ? FW : SW;
    localparam int EW     = btc_pkg::EXT_W;
    localparam int SZW    = 2 * btc_pkg::EXT_W;

    btc_pkg::state_t state_reg, state_next;

    logic                       mode_reg;
    logic [EW-1:0]              width_reg;
    logic [EW-1:0]              height_reg;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [FW-1:0]              fill_f_reg, fill_f_next;
    logic [SW-1:0]              fill_s_reg, fill_s_next;
    logic                       recalc_reg, recalc_next;
    logic [CW-1:0]              recalc_cnt_reg, recalc_cnt_next;
    logic [NCELLS-1:0]          valid_reg, valid_next;
    logic [btc_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       end_reg, end_next;
    logic                       done_reg, done_next;
    logic                       place_reg, place_next;
    logic [PW-1:0]              scan_a_reg, scan_a_next;
    logic [PW-1:0]              scan_b_reg, scan_b_next;
    logic                       scan_end_reg, scan_end_next;
    logic                       hold_reg, hold_next;
    logic                       out_valid_reg, out_valid_next;
    logic [btc_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_done_reg, out_done_next;

    logic [EW-1:0]              w_eff;
    logic [EW-1:0]              h_eff;
    logic [SZW-1:0]             size;
    logic [EW-1:0]              outer_n;
    logic [EW-1:0]              inner_n;
    logic [FW-1:0]              adv_f;
    logic [SW-1:0]              adv_s;
    logic [FW-1:0]              scan_f;
    logic [SW-1:0]              scan_s;
    logic [AW-1:0]              place_idx;
    logic [AW-1:0]              scan_idx;
    logic [CW-1:0]              fill_inc;
    logic                       accept;
    logic                       hit;
    logic                       out_free;

    logic                       ram_we;
    logic [btc_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [btc_pkg::BYTE_W-1:0] ram_rdata;

    // Effective extents and derived sizes
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = EW'(1);
        end
        else if (width_reg > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = EW'(1);
        end
        else if (height_reg > EW'(MAX_HEIGHT))
        begin
            h_eff = EW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign size     = SZW'(w_eff) * SZW'(h_eff);
    assign outer_n  = mode_reg ? h_eff : w_eff;
    assign inner_n  = mode_reg ? w_eff : h_eff;
    assign fill_inc = fill_reg + CW'(1);

    // Next fill coordinate in placement order
    always_comb
    begin
        adv_f = fill_f_reg;
        adv_s = fill_s_reg;
        if (mode_reg)
        begin
            if (EW'(fill_s_reg) == h_eff - EW'(1))
            begin
                adv_s = '0;
                adv_f = fill_f_reg + FW'(1);
            end
            else
            begin
                adv_s = fill_s_reg + SW'(1);
            end
        end
        else
        begin
            if (EW'(fill_f_reg) == w_eff - EW'(1))
            begin
                adv_f = '0;
                adv_s = fill_s_reg + SW'(1);
            end
            else
            begin
                adv_f = fill_f_reg + FW'(1);
            end
        end
    end

    assign scan_f    = mode_reg ? FW'(scan_b_reg) : FW'(scan_a_reg);
    assign scan_s    = mode_reg ? SW'(scan_a_reg) : SW'(scan_b_reg);
    assign place_idx = AW'(fill_f_reg) * AW'(MAX_HEIGHT) + AW'(fill_s_reg);
    assign scan_idx  = AW'(scan_f) * AW'(MAX_HEIGHT) + AW'(scan_s);

    assign byte_stall = (state_reg != btc_pkg::ST_IDLE) || recalc_reg;
    assign accept     = byte_valid && !byte_stall;
    assign hit        = !scan_end_reg && valid_reg[scan_idx];
    assign out_free   = !out_valid_reg || !result_stall;
    assign ram_wdata  = (state_reg == btc_pkg::ST_PLACE) ? byte_reg : in_byte;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        fill_f_next     = fill_f_reg;
        fill_s_next     = fill_s_reg;
        recalc_next     = recalc_reg;
        recalc_cnt_next = recalc_cnt_reg;
        valid_next      = valid_reg;
        byte_next       = byte_reg;
        end_next        = end_reg;
        done_next       = done_reg;
        place_next      = place_reg;
        scan_a_next     = scan_a_reg;
        scan_b_next     = scan_b_reg;
        scan_end_next   = scan_end_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            btc_pkg::ST_IDLE:
            begin
                if (recalc_reg)
                begin
                    recalc_next     = 1'b0;
                    recalc_cnt_next = '0;
                    fill_f_next     = '0;
                    fill_s_next     = '0;
                    state_next      = btc_pkg::ST_RECALC;
                end
                else if (accept)
                begin
                    byte_next = in_byte;
                    end_next  = message_end;
                    if (SZW'(fill_reg) >= size)
                    begin
                        done_next     = 1'b0;
                        place_next    = 1'b1;
                        scan_a_next   = '0;
                        scan_b_next   = '0;
                        scan_end_next = 1'b0;
                        state_next    = btc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        valid_next[place_idx] = 1'b1;
                        fill_next             = fill_inc;
                        fill_f_next           = adv_f;
                        fill_s_next           = adv_s;
                        if (message_end || (SZW'(fill_inc) >= size))
                        begin
                            done_next     = message_end;
                            place_next    = 1'b0;
                            scan_a_next   = '0;
                            scan_b_next   = '0;
                            scan_end_next = 1'b0;
                            state_next    = btc_pkg::ST_SCAN;
                        end
                    end
                end
            end

            btc_pkg::ST_RECALC:
            begin
                if (recalc_cnt_reg == fill_reg)
                begin
                    state_next = btc_pkg::ST_IDLE;
                end
                else
                begin
                    fill_f_next     = adv_f;
                    fill_s_next     = adv_s;
                    recalc_cnt_next = recalc_cnt_reg + CW'(1);
                end
            end

            btc_pkg::ST_PLACE:
            begin
                ram_we                = 1'b1;
                valid_next[place_idx] = 1'b1;
                fill_next             = fill_inc;
                fill_f_next           = adv_f;
                fill_s_next           = adv_s;
                if (end_reg || (SZW'(fill_inc) >= size))
                begin
                    done_next     = end_reg;
                    place_next    = 1'b0;
                    scan_a_next   = '0;
                    scan_b_next   = '0;
                    scan_end_next = 1'b0;
                    state_next    = btc_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = btc_pkg::ST_IDLE;
                end
            end

            btc_pkg::ST_SCAN:
            begin
                if (scan_end_reg)
                begin
                    if (!hold_reg || out_free)
                    begin
                        if (hold_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = ram_rdata;
                            out_last_next  = 1'b1;
                            out_done_next  = done_reg;
                        end
                        hold_next   = 1'b0;
                        valid_next  = '0;
                        fill_next   = '0;
                        fill_f_next = '0;
                        fill_s_next = '0;
                        state_next  = place_reg ? btc_pkg::ST_PLACE : btc_pkg::ST_IDLE;
                    end
                end
                else if (!hit || !hold_reg || out_free)
                begin
                    // advance the scan; on a filled cell, read it and pass on the held one
                    if (hit)
                    begin
                        ram_re = 1'b1;
                        if (hold_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = ram_rdata;
                            out_last_next  = 1'b0;
                            out_done_next  = 1'b0;
                        end
                        hold_next = 1'b1;
                    end
                    if (EW'(scan_b_reg) == inner_n - EW'(1))
                    begin
                        scan_b_next = '0;
                        if (EW'(scan_a_reg) == outer_n - EW'(1))
                        begin
                            scan_end_next = 1'b1;
                        end
                        else
                        begin
                            scan_a_next = scan_a_reg + PW'(1);
                        end
                    end
                    else
                    begin
                        scan_b_next = scan_b_reg + PW'(1);
                    end
                end
            end

            default:
            begin
                state_next = btc_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            recalc_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btc_pkg::ST_IDLE;
            mode_reg       <= 1'b0;
            width_reg      <= btc_pkg::WIDTH_RESET;
            height_reg     <= btc_pkg::HEIGHT_RESET;
            fill_reg       <= '0;
            fill_f_reg     <= '0;
            fill_s_reg     <= '0;
            recalc_reg     <= 1'b0;
            recalc_cnt_reg <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            place_reg      <= 1'b0;
            scan_a_reg     <= '0;
            scan_b_reg     <= '0;
            scan_end_reg   <= 1'b0;
            hold_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            fill_f_reg     <= fill_f_next;
            fill_s_reg     <= fill_s_next;
            recalc_reg     <= recalc_next;
            recalc_cnt_reg <= recalc_cnt_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            place_reg      <= place_next;
            scan_a_reg     <= scan_a_next;
            scan_b_reg     <= scan_b_next;
            scan_end_reg   <= scan_end_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    btc_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                    btc_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    btc_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default:             mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        end_reg      <= end_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    btc_ram #(
        .WIDTH (btc_pkg::BYTE_W),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (place_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = out_last_reg;
    assign message_done = out_done_reg;

endmodule

// ===== hdl/btc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low. No dependencies.
module btc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/tb_block_transposition_cipher.sv =====
// Self-checking testbench for block_transposition_cipher. Needs btc_pkg.
// Runs a directed table and then randomized messages under four idle/stall profiles.
// Every output is checked against a directed row's item or a local transposition predictor.
`timescale 1ns / 1ps

module tb_block_transposition_cipher;
    import btc_pkg::*;

    localparam int MAX_W          = 8;
    localparam int MAX_H          = 8;
    localparam int NCELLS         = MAX_W * MAX_H;
    localparam int QUIET_CYCLES   = 140;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              done;
    } cipher_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [REG_IDX_W-1:0] idx;
        logic [EXT_W-1:0]     val;
        logic [BYTE_W-1:0]    din;
        logic                 eom;
        logic                 has_ref;
        cipher_t              want;
    } row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 byte_valid   = 1'b0;
    logic                 byte_stall;
    logic [BYTE_W-1:0]    in_byte      = '0;
    logic                 message_end  = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 run_last;
    logic                 message_done;
    logic                 cfg_we       = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index    = '0;
    logic [EXT_W-1:0]     cfg_data     = '0;

    logic                 ref_on       = 1'b0;
    cipher_t              ref_item     = '0;

    int                   idle_pct     = 0;
    int                   stall_pct    = 0;
    int                   mismatches   = 0;
    int                   quiet_count  = 0;

    logic [BYTE_W-1:0]    cell_byte [NCELLS] = '{default: '0};
    logic                 cell_full [NCELLS] = '{default: 1'b0};
    int unsigned          filled           = 0;
    logic                 mode_q           = 1'b0;
    logic [EXT_W-1:0]     width_q          = WIDTH_RESET;
    logic [EXT_W-1:0]     height_q         = HEIGHT_RESET;

    cipher_t              cipher_q [$];
    cipher_t              fresh_q [$];
    cipher_t              got;
    cipher_t              want;
    row_t                 dir_rows [$];

    block_transposition_cipher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .message_end  (message_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_done (message_done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp_extent(logic [EXT_W-1:0] v, int unsigned top);
        if (v == '0)
        begin
            return 1;
        end
        if (32'(v) > top)
        begin
            return top;
        end
        return 32'(v);
    endfunction

    function automatic void flush_rect(logic done);
        int unsigned w;
        int unsigned h;
        int unsigned outer_n;
        int unsigned inner_n;
        int unsigned a;
        int unsigned b;
        int unsigned f;
        int unsigned s;
        int unsigned idx;
        int          start;
        w       = clamp_extent(width_q, MAX_W);
        h       = clamp_extent(height_q, MAX_H);
        outer_n = mode_q ? h : w;
        inner_n = mode_q ? w : h;
        start   = fresh_q.size();
        for (a = 0; a < outer_n; a++)
        begin
            for (b = 0; b < inner_n; b++)
            begin
                f   = mode_q ? b : a;
                s   = mode_q ? a : b;
                idx = (f * MAX_H + s) % NCELLS;
                if (cell_full[idx] && fresh_q.size() < NCELLS)
                begin
                    fresh_q.push_back(cipher_t'{cell_byte[idx], 1'b0, 1'b0});
                end
            end
        end
        if (fresh_q.size() > start)
        begin
            fresh_q[$].last = 1'b1;
            fresh_q[$].done = done;
        end
        foreach (cell_full[i])
        begin
            cell_full[i] = 1'b0;
        end
        filled = 0;
    endfunction

    function automatic void cipher_step(logic [BYTE_W-1:0] din, logic eom);
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned f;
        int unsigned s;
        int unsigned idx;
        w    = clamp_extent(width_q, MAX_W);
        h    = clamp_extent(height_q, MAX_H);
        area = w * h;
        if (filled >= area)
        begin
            flush_rect(1'b0);
        end
        if (mode_q)
        begin
            s = filled % h;
            f = filled / h;
        end
        else
        begin
            f = filled % w;
            s = filled / w;
        end
        idx            = (f * MAX_H + s) % NCELLS;
        cell_byte[idx] = din;
        cell_full[idx] = 1'b1;
        filled         = (filled + 1) & 32'h7F;
        if (eom || filled >= area)
        begin
            flush_rect(eom);
        end
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                        logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = cipher_t'{out_byte, run_last, message_done};
                if (cipher_q.size() == 0)
                begin
                    $display("%0t unexpected transaction: expected none actual %h/%b/%b",
                             $time, got.data, got.last, got.done);
                    mismatches++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    check_field("out_byte", want.data, got.data);
                    check_field("run_last", BYTE_W'(want.last), BYTE_W'(got.last));
                    check_field("message_done", BYTE_W'(want.done), BYTE_W'(got.done));
                end
            end
            if (byte_valid && !byte_stall)
            begin
                fresh_q.delete();
                cipher_step(in_byte, message_end);
                if (ref_on)
                begin
                    cipher_q.push_back(ref_item);
                end
                else
                begin
                    foreach (fresh_q[i])
                    begin
                        cipher_q.push_back(fresh_q[i]);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_q   = cfg_data[0];
                    REG_WIDTH:  width_q  = cfg_data;
                    REG_HEIGHT: height_q = cfg_data;
                    default:    ;
                endcase
            end
        end
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall) || cfg_we)
        begin
            quiet_count <= 0;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog expired", $time);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        byte_valid <= 1'b0;
        cfg_we     <= 1'b0;
        @(posedge clk);
        while (cipher_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        drain();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] din, logic eom, logic has_ref, cipher_t rv);
        cfg_we <= 1'b0;
        if ($urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                @(posedge clk);
            end
        end
        byte_valid  <= 1'b1;
        in_byte     <= din;
        message_end <= eom;
        ref_on      <= has_ref;
        ref_item    <= rv;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
    endtask

    function automatic row_t byte_row(logic [BYTE_W-1:0] din, logic eom);
        return '{ROW_BYTE, '0, '0, din, eom, 1'b0, '0};
    endfunction

    function automatic row_t ref_row(logic [BYTE_W-1:0] din, logic eom, cipher_t rv);
        return '{ROW_BYTE, '0, '0, din, eom, 1'b1, rv};
    endfunction

    function automatic row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
        return '{ROW_CFG, idx, val, '0, 1'b0, 1'b0, '0};
    endfunction

    initial
    begin
        int          phase;
        int          sent;
        int          target;
        int          len;
        int          k;
        int unsigned area;
        logic        opening;
        logic        noisy;
        logic        eom;
        logic        mv;
        logic [2:0]  pad;
        logic [3:0]  wv;
        logic [3:0]  hv;

        dir_rows = '{
            ref_row(8'h00, 1'b1, cipher_t'{8'h00, 1'b1, 1'b1}),
            ref_row(8'hFF, 1'b1, cipher_t'{8'hFF, 1'b1, 1'b1}),
            byte_row(8'h11, 1'b0), byte_row(8'h22, 1'b0), byte_row(8'h33, 1'b1),
            cfg_row(REG_WIDTH, 4'd3), cfg_row(REG_HEIGHT, 4'd2),
            byte_row(8'hA0, 1'b0), byte_row(8'hA1, 1'b0), byte_row(8'hA2, 1'b0),
            byte_row(8'hA3, 1'b0), byte_row(8'hA4, 1'b0), byte_row(8'hA5, 1'b0),
            cfg_row(REG_MODE, 4'd1),
            byte_row(8'hB0, 1'b0), byte_row(8'hB1, 1'b0), byte_row(8'hB2, 1'b0),
            byte_row(8'hB3, 1'b1),
            cfg_row(REG_WIDTH, 4'd0), cfg_row(REG_HEIGHT, 4'd0),
            ref_row(8'h5A, 1'b0, cipher_t'{8'h5A, 1'b1, 1'b0}),
            ref_row(8'hA5, 1'b1, cipher_t'{8'hA5, 1'b1, 1'b1}),
            cfg_row(REG_WIDTH, 4'd15), cfg_row(REG_HEIGHT, 4'd15), cfg_row(REG_SPARE, 4'hF),
            byte_row(8'hC0, 1'b0), byte_row(8'hC1, 1'b0), byte_row(8'hC2, 1'b0),
            byte_row(8'hC3, 1'b0), byte_row(8'hC4, 1'b0),
            cfg_row(REG_WIDTH, 4'd1), cfg_row(REG_HEIGHT, 4'd2),
            byte_row(8'hD0, 1'b0), byte_row(8'hD1, 1'b1),
            cfg_row(REG_MODE, 4'hE),
            ref_row(8'hE0, 1'b1, cipher_t'{8'hE0, 1'b1, 1'b1})
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                send_byte(dir_rows[i].din, dir_rows[i].eom, dir_rows[i].has_ref,
                          dir_rows[i].want);
            end
        end

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 85;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 85;
                end
                default:
                begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            case (phase)
                0:
                begin
                    mv = 1'b0; wv = 4'd8; hv = 4'd8;
                end
                1:
                begin
                    mv = 1'b1; wv = 4'd1; hv = 4'd1;
                end
                2:
                begin
                    mv = 1'b1; wv = 4'd8; hv = 4'd8;
                end
                3:
                begin
                    mv = 1'b0; wv = 4'd1; hv = 4'd8;
                end
                4:
                begin
                    mv = 1'b1; wv = 4'd8; hv = 4'd1;
                end
                6:
                begin
                    mv = 1'b0; wv = 4'd3; hv = 4'd5;
                end
                default:
                begin
                    mv = 1'($urandom_range(1));
                    wv = 4'($urandom_range(15));
                    hv = 4'($urandom_range(15));
                end
            endcase
            pad = 3'($urandom_range(7));
            settle();
            write_reg(REG_MODE, {pad, mv});
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);

            area    = clamp_extent(wv, MAX_W) * clamp_extent(hv, MAX_H);
            target  = (area >= 32) ? 75 : 45;
            sent    = 0;
            opening = 1'b1;
            while (sent < target)
            begin
                if (opening && area >= 32)
                begin
                    len = area + $urandom_range(3);
                end
                else
                begin
                    len = $urandom_range(area + 2, 1);
                end
                opening = 1'b0;
                noisy   = ($urandom_range(7) == 0);
                for (k = 0; k < len && sent < target; k++)
                begin
                    eom = noisy ? ($urandom_range(5) == 0) : (k == len - 1);
                    send_byte(8'($urandom_range(255)), eom, 1'b0, '0);
                    sent++;
                    if ($urandom_range(49) == 0)
                    begin
                        drain();
                    end
                end
            end
        end

        drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
